/* hw/rtl/qpi_pkg.sv */
// ----------------------------------------------------------------------------
// qpi_pkg
// Shared constants, types and helpers for the quadtree point insert unit.
// ----------------------------------------------------------------------------
package qpi_pkg;

    localparam int BASE_DEPTH = 6;
    localparam int NODE_COUNT = ((1 << (2 * BASE_DEPTH)) - 1) / 3;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int DEPTH_W    = $clog2(BASE_DEPTH + 1);

    localparam int VAL_W      = 32;
    localparam int COORD_W    = VAL_W + BASE_DEPTH;   // scaled coordinate
    localparam int HALF_W     = (COORD_W + 1) / 2;    // multiplier operand
    localparam int PROD_W     = 2 * HALF_W;
    localparam int DIST_W     = 4 * HALF_W + 2;       // squared distance sum
    localparam int MEM_W      = 3 * VAL_W + 1;        // {valid, tag, y, x}

    localparam int CFG_IDX_W  = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = CFG_IDX_W'(3);

    localparam logic [1:0] PART_LL = 2'd0;  // a0 * a0
    localparam logic [1:0] PART_LH = 2'd1;  // a0 * a1
    localparam logic [1:0] PART_HH = 2'd2;  // a1 * a1

    localparam logic [1:0] DIR_NW = 2'd0;
    localparam logic [1:0] DIR_NE = 2'd1;
    localparam logic [1:0] DIR_SW = 2'd2;
    localparam logic [1:0] DIR_SE = 2'd3;

    localparam logic OUT_FILLED    = 1'b0;
    localparam logic OUT_DISCARDED = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_CALC,
        ST_DRAIN,
        ST_DECIDE,
        ST_FINISH
    } t_state;

    // Coordinate times 2^BASE_DEPTH, sign kept.
    function automatic logic signed [COORD_W-1:0] scale(input logic [VAL_W-1:0] v);
        return {v, {BASE_DEPTH{1'b0}}};
    endfunction

    // (lo + hi) / 2, truncated toward zero.
    function automatic logic signed [COORD_W-1:0] mid(input logic signed [COORD_W-1:0] lo,
                                                      input logic signed [COORD_W-1:0] hi);
        logic signed [COORD_W:0] s;
        logic signed [COORD_W:0] t;
        s = {lo[COORD_W-1], lo} + {hi[COORD_W-1], hi};
        t = s + {{COORD_W{1'b0}}, s[COORD_W] & s[0]};
        return t[COORD_W:1];
    endfunction

endpackage

/* hw/rtl/quadtree_point_insert_unit.sv */
// ----------------------------------------------------------------------------
// quadtree_point_insert_unit
// Inserts points into an implicit quadtree heap; one result item per point.
// ----------------------------------------------------------------------------
// Per level: read, then check; at an occupied level the distances of both points
// to the cell centre are squared as 12 multiply issues through one shared
// multiplier, the multiplier pipeline drains, then decide. Up to 6 levels, then
// the result goes to the output register.
// Flow: one item at a time, the next taken in the cycle after the result is
// loaded; the shared squaring multiplier sets the rate.
// Reset (i_rst_n low, synchronous) restores default bounds, then a clearing
// pass over all 1365 nodes empties the node store before the first item is taken.
module quadtree_point_insert_unit
    import qpi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VAL_W-1:0]     i_cfg_data,
    // input items
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [95:0]          i_s_tdata,   // point_x[31:0], point_y[63:32], point_tag[95:64]
    // result items
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [47:0]          o_m_tdata,   // node_index[10:0], final_tag[42:11],
                                              // swap_count[45:43], zero[47:46]
    output logic                 o_m_tuser    // outcome
);

    t_state r_state, n_state;

    logic [VAL_W-1:0] r_bminx, r_bminy, r_bmaxx, r_bmaxy;

    logic [MEM_W-1:0] r_mem [NODE_COUNT];
    logic [MEM_W-1:0] r_rd;
    logic             w_we;
    logic [NODE_W-1:0] w_waddr;
    logic [MEM_W-1:0] w_wdata;

    logic [NODE_W-1:0] r_clr_addr;
    logic signed [COORD_W-1:0] r_lox, r_hix, r_loy, r_hiy, r_mx, r_my;
    logic [VAL_W-1:0] r_cx, r_cy, r_ctag, r_ox, r_oy, r_otag;
    logic [NODE_W-1:0] r_pos;
    logic [DEPTH_W-1:0] r_depth;
    logic [2:0] r_swaps;

    // multiply pipeline
    logic [1:0] r_sq, r_part;
    logic       r_v1, r_old1, r_v2, r_old2;
    logic [1:0] r_part1, r_part2;
    logic [HALF_W-1:0] r_op_a, r_op_b;
    logic [PROD_W-1:0] r_prod;
    logic [DIST_W-1:0] r_dn, r_do;

    logic             r_res_outcome;
    logic [NODE_W-1:0] r_res_index;
    logic [VAL_W-1:0] r_res_tag;

    logic             r_out_valid, r_out_outcome;
    logic [10:0]      r_out_index;
    logic [VAL_W-1:0] r_out_tag;
    logic [2:0]       r_out_swaps;

    logic w_in_acc, w_out_load, w_issue_last, w_less, w_west, w_south;
    logic [VAL_W-1:0] w_sel_c, w_nx, w_ny;
    logic signed [COORD_W-1:0] w_sel_m, w_px, w_py;
    logic signed [COORD_W:0] w_diff;
    logic [COORD_W:0] w_abs;
    logic [PROD_W-1:0] w_mag;
    logic [DIST_W-1:0] w_term;
    logic [1:0] w_dir;

    assign w_in_acc     = i_s_tvalid && o_s_tready;
    assign w_out_load   = (r_state == ST_FINISH) && (!r_out_valid || i_m_tready);
    assign w_issue_last = (r_sq == 2'd3) && (r_part == PART_HH);
    assign w_less       = r_dn < r_do;

    // operand for the current issue: new point dx, dy, then stored point dx, dy
    always_comb begin
        case (r_sq)
            2'd0:    begin w_sel_c = r_cx; w_sel_m = r_mx; end
            2'd1:    begin w_sel_c = r_cy; w_sel_m = r_my; end
            2'd2:    begin w_sel_c = r_ox; w_sel_m = r_mx; end
            default: begin w_sel_c = r_oy; w_sel_m = r_my; end
        endcase
        w_diff = {w_sel_c[VAL_W-1], scale(w_sel_c)} - {w_sel_m[COORD_W-1], w_sel_m};
        w_abs  = w_diff[COORD_W] ? (~w_diff + 1'b1) : w_diff;
        w_mag  = PROD_W'(w_abs);
    end

    always_comb begin
        case (r_part2)
            PART_LL: w_term = DIST_W'(r_prod);
            PART_LH: w_term = DIST_W'(r_prod) << (HALF_W + 1);
            default: w_term = DIST_W'(r_prod) << (2 * HALF_W);
        endcase
    end

    // descent after a possible swap
    always_comb begin
        w_nx    = w_less ? r_ox : r_cx;
        w_ny    = w_less ? r_oy : r_cy;
        w_px    = scale(w_nx);
        w_py    = scale(w_ny);
        w_west  = w_px < r_mx;
        w_south = w_py < r_my;
        case ({w_west, w_south})
            2'b11:   w_dir = DIR_SW;
            2'b10:   w_dir = DIR_NW;
            2'b01:   w_dir = DIR_SE;
            default: w_dir = DIR_NE;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (r_clr_addr == NODE_W'(NODE_COUNT - 1)) n_state = ST_IDLE;
            ST_IDLE:   if (w_in_acc) n_state = ST_READ;
            ST_READ:   n_state = ST_CHECK;
            ST_CHECK:  n_state = r_rd[MEM_W-1] ? ST_CALC : ST_FINISH;
            ST_CALC:   if (w_issue_last) n_state = ST_DRAIN;
            ST_DRAIN:  if (!r_v1) n_state = ST_DECIDE;
            ST_DECIDE: n_state = (r_depth == DEPTH_W'(BASE_DEPTH - 1)) ? ST_FINISH : ST_READ;
            ST_FINISH: if (w_out_load) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    // outputs and store controls
    always_comb begin
        o_s_tready = (r_state == ST_IDLE);
        o_cfg_ready = 1'b1;
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = {1'b1, r_ctag, r_cy, r_cx};
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            ST_CHECK:  w_we = !r_rd[MEM_W-1];
            ST_DECIDE: w_we = w_less;
            default:   w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_bminx     <= 32'h8000_0000;
            r_bminy     <= 32'h8000_0000;
            r_bmaxx     <= 32'h7FFF_FFFF;
            r_bmaxy     <= 32'h7FFF_FFFF;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_X: r_bminx <= i_cfg_data;
                    CFG_MIN_Y: r_bminy <= i_cfg_data;
                    CFG_MAX_X: r_bmaxx <= i_cfg_data;
                    CFG_MAX_Y: r_bmaxy <= i_cfg_data;
                    default:   ;
                endcase
            end

            r_v1 <= (r_state == ST_CALC);
            r_v2 <= r_v1;

            if (w_out_load) r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_old1  <= r_sq[1];
        r_part1 <= r_part;
        case (r_part)
            PART_LL: begin r_op_a <= w_mag[HALF_W-1:0]; r_op_b <= w_mag[HALF_W-1:0]; end
            PART_LH: begin r_op_a <= w_mag[HALF_W-1:0]; r_op_b <= w_mag[PROD_W-1:HALF_W]; end
            default: begin
                r_op_a <= w_mag[PROD_W-1:HALF_W];
                r_op_b <= w_mag[PROD_W-1:HALF_W];
            end
        endcase
        r_prod  <= r_op_a * r_op_b;
        r_old2  <= r_old1;
        r_part2 <= r_part1;
        if (r_v2) begin
            if (r_old2) r_do <= r_do + w_term;
            else        r_dn <= r_dn + w_term;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_cx    <= i_s_tdata[31:0];
                    r_cy    <= i_s_tdata[63:32];
                    r_ctag  <= i_s_tdata[95:64];
                    r_lox   <= scale(r_bminx);
                    r_loy   <= scale(r_bminy);
                    r_hix   <= scale(r_bmaxx);
                    r_hiy   <= scale(r_bmaxy);
                    r_pos   <= '0;
                    r_depth <= '0;
                    r_swaps <= '0;
                end
            end
            ST_READ: begin
                r_mx <= mid(r_lox, r_hix);
                r_my <= mid(r_loy, r_hiy);
            end
            ST_CHECK: begin
                r_ox   <= r_rd[VAL_W-1:0];
                r_oy   <= r_rd[2*VAL_W-1:VAL_W];
                r_otag <= r_rd[3*VAL_W-1:2*VAL_W];
                r_sq   <= 2'd0;
                r_part <= PART_LL;
                r_dn   <= '0;
                r_do   <= '0;
                if (!r_rd[MEM_W-1]) begin
                    r_res_outcome <= OUT_FILLED;
                    r_res_index   <= r_pos;
                    r_res_tag     <= r_ctag;
                end
            end
            ST_CALC: begin
                if (r_part == PART_HH) begin
                    r_part <= PART_LL;
                    r_sq   <= r_sq + 1'b1;
                end else begin
                    r_part <= r_part + 1'b1;
                end
            end
            ST_DECIDE: begin
                if (w_less) begin
                    r_cx    <= r_ox;
                    r_cy    <= r_oy;
                    r_ctag  <= r_otag;
                    r_swaps <= r_swaps + 1'b1;
                end
                if (w_west) r_hix <= r_mx; else r_lox <= r_mx;
                if (w_south) r_hiy <= r_my; else r_loy <= r_my;
                r_pos   <= NODE_W'({r_pos, 2'b00} + 1'b1 + w_dir);
                r_depth <= r_depth + 1'b1;
                r_res_outcome <= OUT_DISCARDED;
                r_res_index   <= r_pos;
                r_res_tag     <= w_less ? r_otag : r_ctag;
            end
            default: ;
        endcase

        if (w_out_load) begin
            r_out_outcome <= r_res_outcome;
            r_out_index   <= 11'(r_res_index);
            r_out_tag     <= r_res_tag;
            r_out_swaps   <= r_swaps;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_swaps, r_out_tag, r_out_index};
    assign o_m_tuser  = r_out_outcome;

endmodule

/* tb/quadtree_point_insert_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadtree_point_insert_unit_tb
// Streams points into the quadtree insert unit and checks every result item
// against a behavioral tree kept in the bench, across several bound settings.
// ----------------------------------------------------------------------------
module quadtree_point_insert_unit_tb
    import qpi_pkg::*;
();

    localparam int NODES     = 1365;
    localparam int LEVELS    = 6;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] y;
        logic [31:0] x;
    } t_point;

    typedef struct {
        logic        outcome;
        logic [10:0] node_index;
        logic [31:0] final_tag;
        logic [2:0]  swap_count;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [VAL_W-1:0] i_cfg_data = '0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [95:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;
    logic o_m_tuser;

    quadtree_point_insert_unit DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // tree model
    logic        tree_valid [NODES];
    logic [31:0] tree_x [NODES];
    logic [31:0] tree_y [NODES];
    logic [31:0] tree_tag [NODES];
    logic [31:0] bnd [4];

    t_point  point_q[$];
    t_result expect_q[$];
    int      n_err = 0;
    int      n_in = 0;
    int      n_out = 0;
    int      n_discard = 0;
    int      n_swapped = 0;
    int      hold_off = 0;
    int      idle_cnt = 0;

    function automatic logic signed [39:0] scl(input logic [31:0] v);
        return 40'(signed'(v)) <<< LEVELS;
    endfunction

    function automatic logic [129:0] dist2(input logic signed [39:0] px, py, mx, my);
        logic signed [40:0] dx;
        logic signed [40:0] dy;
        logic [81:0] ax;
        logic [81:0] ay;
        dx = 41'(px) - 41'(mx);
        dy = 41'(py) - 41'(my);
        ax = dx < 0 ? 82'(-dx) : 82'(dx);
        ay = dy < 0 ? 82'(-dy) : 82'(dy);
        return 130'(ax * ax) + 130'(ay * ay);
    endfunction

    function automatic logic signed [39:0] half_sum(input logic signed [39:0] a, b);
        logic signed [40:0] s;
        s = 41'(a) + 41'(b);
        return 40'(s / 2);
    endfunction

    function automatic t_result insert_point(input t_point p);
        t_result r;
        logic signed [39:0] lox, loy, hix, hiy, mx, my;
        int unsigned pos;
        int unsigned last;
        int          swaps;
        logic [31:0] cx, cy, ct, ox, oy, ot;
        logic [1:0]  dir;
        lox = scl(bnd[CFG_MIN_X]); loy = scl(bnd[CFG_MIN_Y]);
        hix = scl(bnd[CFG_MAX_X]); hiy = scl(bnd[CFG_MAX_Y]);
        cx = p.x; cy = p.y; ct = p.tag;
        pos = 0; last = 0; swaps = 0;
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            mx = half_sum(lox, hix);
            my = half_sum(loy, hiy);
            if (!tree_valid[pos]) begin
                tree_valid[pos] = 1'b1;
                tree_x[pos] = cx; tree_y[pos] = cy; tree_tag[pos] = ct;
                r.outcome = OUT_FILLED;
                r.node_index = 11'(pos);
                r.final_tag = ct;
                r.swap_count = 3'(swaps);
                return r;
            end
            if (dist2(scl(cx), scl(cy), mx, my) <
                    dist2(scl(tree_x[pos]), scl(tree_y[pos]), mx, my)) begin
                ox = tree_x[pos]; oy = tree_y[pos]; ot = tree_tag[pos];
                tree_x[pos] = cx; tree_y[pos] = cy; tree_tag[pos] = ct;
                cx = ox; cy = oy; ct = ot;
                swaps++;
            end
            last = pos;
            if (scl(cx) < mx) begin
                hix = mx;
                dir = (scl(cy) < my) ? DIR_SW : DIR_NW;
            end else begin
                lox = mx;
                dir = (scl(cy) < my) ? DIR_SE : DIR_NE;
            end
            if (scl(cy) < my) hiy = my; else loy = my;
            pos = pos * 4 + 1 + dir;
        end
        r.outcome = OUT_DISCARDED;
        r.node_index = 11'(last);
        r.final_tag = ct;
        r.swap_count = 3'(swaps);
        return r;
    endfunction

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expect_q.insert(expect_q.size(), insert_point(t_point'(i_s_tdata)));
                n_in++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (point_q.size() > 0) begin
                    i_s_tdata <= point_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern plus a long hold-off on request
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_tready <= 1'b0;
        end else if (stall_phase[9:8] == 2'd0) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_out++;
            if (expect_q.size() == 0) begin
                $error("result item with nothing expected");
                n_err++;
            end else begin
                e = expect_q.pop_front();
                if (o_m_tuser !== e.outcome) begin
                    $error("outcome exp %0d got %0d", e.outcome, o_m_tuser);
                    n_err++;
                end
                if (o_m_tdata[10:0] !== e.node_index) begin
                    $error("node_index exp %0d got %0d", e.node_index, o_m_tdata[10:0]);
                    n_err++;
                end
                if (o_m_tdata[42:11] !== e.final_tag) begin
                    $error("final_tag exp %h got %h", e.final_tag, o_m_tdata[42:11]);
                    n_err++;
                end
                if (o_m_tdata[45:43] !== e.swap_count) begin
                    $error("swap_count exp %0d got %0d", e.swap_count, o_m_tdata[45:43]);
                    n_err++;
                end
                if (e.outcome == OUT_DISCARDED) n_discard++;
                if (e.swap_count != 0) n_swapped++;
            end
        end
    end

    // watchdog: clearing pass and deep insertions fit well inside the limit
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt >= WDOG_MAX) begin
            $display("watchdog expired, %0d items in, %0d results out", n_in, n_out);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_bound(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx <= CFG_MAX_Y) bnd[idx] = val;
    endtask

    task automatic wait_drained();
        while (point_q.size() > 0 || i_s_tvalid || expect_q.size() > 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic logic [31:0] coord_rand(input logic [31:0] lo, hi, input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 1) ? lo : hi;
            default: return lo + $urandom_range(0, 3) * ((hi - lo) >> 2)
                         + 32'($urandom_range(0, 7)) - 32'd3;
        endcase
    endfunction

    task automatic add_random(input int count);
        t_point p;
        int m;
        for (int k = 0; k < count; k++) begin
            m = $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 2);
            p.x = coord_rand(bnd[CFG_MIN_X], bnd[CFG_MAX_X], m);
            p.y = coord_rand(bnd[CFG_MIN_Y], bnd[CFG_MAX_Y], m);
            // narrow clusters force deep descents and displacements
            if ($urandom_range(0, 3) == 0) begin
                p.x = (bnd[CFG_MIN_X] >>> 1) + (bnd[CFG_MAX_X] >>> 1) + 32'($urandom_range(0, 255));
                p.y = (bnd[CFG_MIN_Y] >>> 1) + (bnd[CFG_MAX_Y] >>> 1) + 32'($urandom_range(0, 255));
            end
            p.tag = $urandom();
            point_q.insert(point_q.size(), p);
        end
    endtask

    task automatic add_point(input logic [31:0] x, y, tag);
        t_point p;
        p.x = x; p.y = y; p.tag = tag;
        point_q.insert(point_q.size(), p);
    endtask

    initial begin
        for (int n = 0; n < NODES; n++) tree_valid[n] = 1'b0;
        bnd[CFG_MIN_X] = 32'h8000_0000; bnd[CFG_MIN_Y] = 32'h8000_0000;
        bnd[CFG_MAX_X] = 32'h7fff_ffff; bnd[CFG_MAX_Y] = 32'h7fff_ffff;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, midpoint ties, equal distances, unknown index
        write_bound(8'd4, 32'hdead_beef);
        write_bound(8'hff, 32'h1234_5678);
        add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        add_point(32'h0000_0000, 32'h0000_0000, 32'hffff_ffff);
        add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0002);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0003);
        add_point(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0004);
        add_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0005);
        add_point(32'hffff_ffff, 32'hffff_ffff, 32'h5555_5555);
        add_point(32'h0000_0001, 32'hffff_ffff, 32'haaaa_aaaa);
        add_point(32'hffff_ffff, 32'h0000_0001, 32'h0000_0006);
        add_point(32'hffff_ffff, 32'h0000_0000, 32'h0000_0007);
        for (int k = 0; k < 8; k++) add_point(32'h0000_0000, 32'h0000_0000, 32'(100 + k));
        wait_drained();

        // long hold-off at the output while points keep coming
        add_random(40);
        hold_off = 400;
        wait_drained();

        // small window, then inverted bounds, then a window of zero width in x
        write_bound(CFG_MIN_X, 32'hffff_0000);
        write_bound(CFG_MIN_Y, 32'hffff_0000);
        write_bound(CFG_MAX_X, 32'h0001_0000);
        write_bound(CFG_MAX_Y, 32'h0001_0000);
        add_random(400);
        wait_drained();
        write_bound(CFG_MIN_X, 32'h7fff_ffff);
        write_bound(CFG_MAX_X, 32'h8000_0000);
        write_bound(CFG_MIN_Y, 32'h0000_1000);
        write_bound(CFG_MAX_Y, 32'hffff_f000);
        add_random(350);
        wait_drained();
        write_bound(CFG_MIN_X, 32'h0000_0000);
        write_bound(CFG_MAX_X, 32'h0000_0000);
        write_bound(CFG_MIN_Y, 32'h8000_0000);
        write_bound(CFG_MAX_Y, 32'h7fff_ffff);
        add_random(450);
        wait_drained();

        $display("%0d points inserted over 4 bound settings, %0d discarded, %0d with swaps",
                 n_in, n_discard, n_swapped);
        if (n_err == 0 && expect_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* quadtree_point_insert_unit.f */
hw/rtl/qpi_pkg.sv
hw/rtl/quadtree_point_insert_unit.sv
tb/quadtree_point_insert_unit_tb.sv
